FILE: rtl/core/pyro_fire_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Pyro fire sequencer assertion macros
// Concurrent assertion shorthands shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef PYRO_FIRE_SEQUENCER_ASSERT_SVH
`define PYRO_FIRE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PYRO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PYRO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pyro_pkg.sv
// ----------------------------------------------------------------------------
// Pyro fire sequencer package
// Shared widths, codes and interface types of the fire sequencer.
// ----------------------------------------------------------------------------
package pyro_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 8;
  localparam int unsigned MAX_RETRIES     = 3;

  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned CONT_W    = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned QUEUED_W  = 4;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned NUM_CH    = 3;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [TICKS_W-1:0]   PULSE_TICKS_RESET = 16'd1000;
  localparam logic [CHANNEL_W-1:0] CH_INVALID        = 2'd3;

  typedef enum logic {
    ACT_REQUEST = 1'b0,
    ACT_TICK    = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_PULSE_TICKS = 1'b0
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_BUSY        = 3'd1,
    ST_IDLE_TICK   = 3'd2,
    ST_INVALID     = 3'd3,
    ST_PULSE_START = 3'd4,
    ST_PULSE_DONE  = 3'd5,
    ST_RETRY_QUEUE = 3'd6,
    ST_RETRY_LOST  = 3'd7
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/core/pyro_fifo.sv
// ----------------------------------------------------------------------------
// Pyro request FIFO
// Channel code queue with a registered head read and write forwarding.
// ----------------------------------------------------------------------------
module pyro_fifo #(
  parameter int unsigned DEPTH = pyro_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pyro_pkg::fifo_ctrl_t           ctrl,
  input  logic [pyro_pkg::CHANNEL_W-1:0] push_code,
  output logic [pyro_pkg::CHANNEL_W-1:0] head,
  output logic [$clog2(DEPTH+1)-1:0]     count,
  output pyro_pkg::fifo_stat_t           stat
);
  import pyro_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CHANNEL_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr_next;
  logic [PTR_W-1:0]     wr_ptr_next;
  logic [CNT_W-1:0]     count_next;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      head <= push_code;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule

FILE: rtl/core/pyro_fire_sequencer.sv
// ----------------------------------------------------------------------------
// Pyro fire sequencer
// Queues fire requests and drives timed igniter pulses with retries.
// ----------------------------------------------------------------------------
// Channel  Handshake          Payload
// in       in_valid/in_stall  action, channel, continuity
// out      out_valid/out_stall status, fire_lines, queued
// cfg      APB write/read     pulse_ticks at byte address 0
//
// One item per cycle while the result register is not stalled; an item's result
// is loaded into the result register from the input register.
// The input register feeds one pass of logic that updates the FIFO, timer and
// retry counters and loads the result register.
// A stalled result register holds the input register, which then stalls in.
// Synchronous reset empties the FIFO, stops any pulse and restores retries.
// ----------------------------------------------------------------------------
module pyro_fire_sequencer #(
  parameter int unsigned QUEUE_DEPTH = pyro_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [pyro_pkg::CHANNEL_W-1:0] channel,
  input  logic [pyro_pkg::CONT_W-1:0]    continuity,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pyro_pkg::STATUS_W-1:0]  status,
  output logic [pyro_pkg::NUM_CH-1:0]    fire_lines,
  output logic [pyro_pkg::QUEUED_W-1:0]  queued,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pyro_pkg::PADDR_W-1:0]   paddr,
  input  logic [pyro_pkg::PDATA_W-1:0]   pwdata,
  output logic [pyro_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import pyro_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [TICKS_W-1:0]   pulse_ticks;
  logic                 reg_hit;

  logic                 s_valid;
  action_t              s_action;
  logic [CHANNEL_W-1:0] s_channel;
  logic [CONT_W-1:0]    s_cont;
  logic                 fire;

  logic                 pulse_active;
  logic                 pulse_active_next;
  logic [CHANNEL_W-1:0] active_channel;
  logic [CHANNEL_W-1:0] active_channel_next;
  logic [TICKS_W-1:0]   pulse_remaining;
  logic [TICKS_W-1:0]   pulse_remaining_next;
  logic [TICKS_W-1:0]   rem_dec;
  logic [RETRY_W-1:0]   retries [NUM_CH];
  logic                 retry_take;

  fifo_ctrl_t           fctrl;
  fifo_stat_t           fstat;
  logic [CHANNEL_W-1:0] push_code;
  logic [CHANNEL_W-1:0] head;
  logic [CNT_W-1:0]     fcount;
  logic [CNT_W-1:0]     count_after;

  status_t              st_next;
  logic [NUM_CH-1:0]    lines_next;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_PULSE_TICKS);
  assign prdata  = reg_hit ? PDATA_W'(pulse_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pulse_ticks <= pwdata[TICKS_W-1:0];
    end
  end

  // Input register.
  assign fire     = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_action  <= action_t'(action);
      s_channel <= channel;
      s_cont    <= continuity;
    end
  end

  pyro_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (fctrl),
    .push_code(push_code),
    .head     (head),
    .count    (fcount),
    .stat     (fstat)
  );

  // Per-item update.
  assign rem_dec = (pulse_remaining != '0) ? pulse_remaining - 1'b1 : pulse_remaining;

  always_comb begin
    st_next              = ST_IDLE_TICK;
    fctrl                = '0;
    push_code            = s_channel;
    retry_take           = 1'b0;
    pulse_active_next    = pulse_active;
    active_channel_next  = active_channel;
    pulse_remaining_next = pulse_remaining;
    if (s_action == ACT_REQUEST) begin
      fctrl.push = !fstat.full;
      st_next    = fstat.full ? ST_BUSY : ST_ACCEPTED;
    end else if (pulse_active) begin
      pulse_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        pulse_active_next = 1'b0;
        st_next           = ST_PULSE_DONE;
        push_code         = active_channel;
        if ((active_channel != CH_INVALID) && s_cont[active_channel]
            && (retries[active_channel] != '0)) begin
          retry_take = 1'b1;
          fctrl.push = !fstat.full;
          st_next    = fstat.full ? ST_RETRY_LOST : ST_RETRY_QUEUE;
        end
      end
    end else if (!fstat.empty) begin
      fctrl.pop = 1'b1;
      if (head == CH_INVALID) begin
        st_next = ST_INVALID;
      end else begin
        st_next              = ST_PULSE_START;
        pulse_active_next    = 1'b1;
        active_channel_next  = head;
        pulse_remaining_next = (pulse_ticks == '0) ? TICKS_W'(1) : pulse_ticks;
      end
    end
    fctrl.push = fctrl.push && fire;
    fctrl.pop  = fctrl.pop && fire;
  end

  always_comb begin
    count_after = fcount;
    if (fctrl.push) begin
      count_after = fcount + 1'b1;
    end else if (fctrl.pop) begin
      count_after = fcount - 1'b1;
    end
  end

  always_comb begin
    lines_next = '0;
    if (pulse_active_next && (active_channel_next != CH_INVALID)) begin
      lines_next[active_channel_next] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_active    <= 1'b0;
      active_channel  <= '0;
      pulse_remaining <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        retries[i] <= RETRY_W'(MAX_RETRIES);
      end
    end else if (fire) begin
      pulse_active    <= pulse_active_next;
      active_channel  <= active_channel_next;
      pulse_remaining <= pulse_remaining_next;
      if (retry_take) begin
        retries[active_channel] <= retries[active_channel] - 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status     <= st_next;
      fire_lines <= lines_next;
      queued     <= QUEUED_W'(count_after);
    end
  end

  `include "pyro_fire_sequencer_assert.svh"

  `PYRO_ASSERT_SAME(a_lines_onehot, out_valid, $onehot0(fire_lines), "more than one fire line high")
  `PYRO_ASSERT_NEXT(a_start_pops, fire && (st_next == ST_PULSE_START), fcount == $past(fcount) - 1'b1, "pulse start without a pop")
  `PYRO_ASSERT_NEXT(a_accept_pushes, fire && (st_next == ST_ACCEPTED), fcount == $past(fcount) + 1'b1, "accepted request not queued")
  `PYRO_ASSERT_SAME(a_pulse_timer, pulse_active, pulse_remaining != '0, "active pulse with an expired timer")

endmodule
